### sv/lbsm_pkg.sv
package lbsm_pkg;

	localparam int COLOR_W   = 15;
	localparam int CH_W      = 5;
	localparam int NUM_CH    = 3;
	localparam int NUM_BG    = 4;
	localparam int NUM_LAYER = NUM_BG + 1;
	localparam int NUM_PRIO  = 4;
	localparam int NUM_POS   = NUM_PRIO * NUM_LAYER;
	localparam int LAYER_W   = 3;
	localparam int BACKDROP_BIT = 5;

	localparam logic [LAYER_W-1:0] LAYER_SPRITE = 3'd4;
	localparam logic [CH_W-1:0]    CH_MAX       = 5'd31;
	localparam logic [CH_W-1:0]    WEIGHT_CAP   = 5'd17;

	typedef logic [COLOR_W-1:0] color_t;
	typedef logic [LAYER_W-1:0] layer_t;

	typedef enum logic [1:0] {
		MODE_NONE  = 2'b00,
		MODE_ALPHA = 2'b01,
		MODE_WHITE = 2'b10,
		MODE_BLACK = 2'b11
	} mode_t;

	typedef enum logic [2:0] {
		REG_LAYER_ENABLE  = 3'd0,
		REG_BG_PRIORITIES = 3'd1,
		REG_BLEND_MODE    = 3'd2,
		REG_FIRST_TARGET  = 3'd3,
		REG_SECOND_TARGET = 3'd4,
		REG_ALPHA_FIRST   = 3'd5,
		REG_ALPHA_SECOND  = 3'd6,
		REG_FADE_WEIGHT   = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [4:0] layer_enable;
		logic [7:0] bg_priorities;
		mode_t      blend_mode;
		logic [5:0] first_target_mask;
		logic [5:0] second_target_mask;
		logic [4:0] alpha_weight_first;
		logic [4:0] alpha_weight_second;
		logic [4:0] fade_weight;
	} cfg_t;

	typedef struct packed {
		color_t [NUM_BG-1:0] bg_color;
		logic [NUM_BG-1:0]   bg_opaque;
		color_t              sprite_color;
		logic                sprite_opaque;
		logic [1:0]          sprite_priority;
		logic                sprite_semi;
		color_t              backdrop_color;
	} pix_t;

	typedef struct packed {
		logic   do_alpha;
		logic   do_fade;
		layer_t layer;
		color_t a_color;
		color_t b_color;
	} sel_t;

	typedef struct packed {
		logic   modified;
		layer_t target_layer;
		color_t new_color;
	} res_t;

	function automatic logic [CH_W-1:0] cap_weight(input logic [CH_W-1:0] w);
		return (w > WEIGHT_CAP) ? WEIGHT_CAP : w;
	endfunction

endpackage

### sv/lbsm_cfg_regs.sv
module lbsm_cfg_regs
	import lbsm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr;

	assign idx    = reg_idx_t'(paddr[4:2]);
	assign wr     = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr) begin
			unique case (idx)
				REG_LAYER_ENABLE:  cfg_q.layer_enable        <= pwdata[4:0];
				REG_BG_PRIORITIES: cfg_q.bg_priorities       <= pwdata[7:0];
				REG_BLEND_MODE:    cfg_q.blend_mode          <= mode_t'(pwdata[1:0]);
				REG_FIRST_TARGET:  cfg_q.first_target_mask   <= pwdata[5:0];
				REG_SECOND_TARGET: cfg_q.second_target_mask  <= pwdata[5:0];
				REG_ALPHA_FIRST:   cfg_q.alpha_weight_first  <= pwdata[4:0];
				REG_ALPHA_SECOND:  cfg_q.alpha_weight_second <= pwdata[4:0];
				REG_FADE_WEIGHT:   cfg_q.fade_weight         <= pwdata[4:0];
				default:           cfg_q <= cfg_q;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_LAYER_ENABLE:  prdata = 32'(cfg_q.layer_enable);
			REG_BG_PRIORITIES: prdata = 32'(cfg_q.bg_priorities);
			REG_BLEND_MODE:    prdata = 32'(cfg_q.blend_mode);
			REG_FIRST_TARGET:  prdata = 32'(cfg_q.first_target_mask);
			REG_SECOND_TARGET: prdata = 32'(cfg_q.second_target_mask);
			REG_ALPHA_FIRST:   prdata = 32'(cfg_q.alpha_weight_first);
			REG_ALPHA_SECOND:  prdata = 32'(cfg_q.alpha_weight_second);
			REG_FADE_WEIGHT:   prdata = 32'(cfg_q.fade_weight);
			default:           prdata = '0;
		endcase
	end

endmodule

### sv/lbsm_layer_select.sv
module lbsm_layer_select
	import lbsm_pkg::*;
(
	input  cfg_t cfg,
	input  pix_t pix,
	output sel_t sel
);

	localparam int POS_W = $clog2(NUM_POS);

	always_comb begin : pick
		logic                 spr_vis;
		logic                 pre_a;
		logic [NUM_LAYER-1:0] cnt;
		logic [1:0]           prio [NUM_LAYER];
		color_t               col [NUM_LAYER];
		layer_t               pos_lyr [NUM_POS];
		logic [NUM_POS-1:0]   hit;
		logic [NUM_POS-1:0]   first_oh;
		logic [NUM_POS-1:0]   rest;
		logic [NUM_POS-1:0]   second_oh;
		layer_t               l1;
		layer_t               l2;
		logic                 f1;
		logic                 f2;
		logic                 a_ok;
		layer_t               a_layer;
		color_t               a_col;
		logic                 b_valid;
		layer_t               b_layer;
		logic                 b_ok;
		color_t               b_col;
		logic                 pair_ok;
		logic                 single_ok;
		layer_t               s_layer;
		color_t               s_col;
		layer_t               first_bg;
		logic [POS_W-1:0]     n;
		logic                 fade_mode;

		spr_vis = cfg.layer_enable[NUM_BG] & pix.sprite_opaque;
		pre_a   = spr_vis & pix.sprite_semi;

		for (int k = 0; k < NUM_BG; k++) begin
			cnt[k]  = cfg.layer_enable[k] & pix.bg_opaque[k];
			prio[k] = cfg.bg_priorities[2*k +: 2];
			col[k]  = pix.bg_color[k];
		end
		cnt[NUM_BG]  = spr_vis & ~pix.sprite_semi;
		prio[NUM_BG] = pix.sprite_priority;
		col[NUM_BG]  = pix.sprite_color;

		// walk order: per priority level, sprite first, then backgrounds
		for (int pr = 0; pr < NUM_PRIO; pr++) begin
			for (int s = 0; s < NUM_LAYER; s++) begin
				n = POS_W'(pr * NUM_LAYER + s);
				pos_lyr[n] = (s == 0) ? LAYER_SPRITE : LAYER_W'(s - 1);
				hit[n] = cnt[pos_lyr[n]] && (prio[pos_lyr[n]] == 2'(pr));
			end
		end

		first_oh  = hit & (~hit + NUM_POS'(1));
		rest      = hit & ~first_oh;
		second_oh = rest & (~rest + NUM_POS'(1));
		f1 = |hit;
		f2 = |rest;
		l1 = '0;
		l2 = '0;
		for (int i = 0; i < NUM_POS; i++) begin
			if (first_oh[i])  l1 = l1 | pos_lyr[i];
			if (second_oh[i]) l2 = l2 | pos_lyr[i];
		end

		// alpha pair
		a_ok    = pre_a | (f1 & cfg.first_target_mask[l1]);
		a_layer = pre_a ? LAYER_SPRITE : l1;
		a_col   = pre_a ? pix.sprite_color : col[l1];
		b_valid = pre_a ? f1 : f2;
		b_layer = pre_a ? l1 : l2;
		b_ok    = b_valid ? cfg.second_target_mask[b_layer]
		                  : cfg.second_target_mask[BACKDROP_BIT];
		b_col   = b_valid ? col[b_layer] : pix.backdrop_color;
		pair_ok = a_ok & b_ok;

		// single target for fades
		first_bg = '0;
		for (int k = NUM_BG - 1; k >= 0; k--) begin
			if (cfg.layer_enable[k]) first_bg = LAYER_W'(k);
		end
		if (pre_a) begin
			single_ok = 1'b1;
			s_layer   = LAYER_SPRITE;
			s_col     = pix.sprite_color;
		end else if (f1) begin
			single_ok = cfg.first_target_mask[l1];
			s_layer   = l1;
			s_col     = col[l1];
		end else begin
			single_ok = cfg.first_target_mask[BACKDROP_BIT] & (|cfg.layer_enable[NUM_BG-1:0]);
			s_layer   = first_bg;
			s_col     = pix.backdrop_color;
		end

		fade_mode    = (cfg.blend_mode == MODE_WHITE) || (cfg.blend_mode == MODE_BLACK);
		sel.do_alpha = pair_ok & (pix.sprite_semi | (cfg.blend_mode == MODE_ALPHA));
		sel.do_fade  = ~sel.do_alpha & fade_mode & single_ok;
		sel.layer    = sel.do_alpha ? a_layer : s_layer;
		sel.a_color  = sel.do_alpha ? a_col : s_col;
		sel.b_color  = b_col;
	end

endmodule

### sv/lbsm_color_mix.sv
module lbsm_color_mix
	import lbsm_pkg::*;
(
	input  cfg_t cfg,
	input  sel_t sel,
	output res_t res
);

	always_comb begin : mix
		logic [CH_W-1:0] ea;
		logic [CH_W-1:0] eb;
		logic [CH_W-1:0] ey;
		logic [CH_W-1:0] ca;
		logic [CH_W-1:0] cb;
		logic [CH_W-1:0] inv;
		logic [9:0]      pa;
		logic [9:0]      pb;
		logic [9:0]      pw;
		logic [9:0]      pk;
		logic [10:0]     asum;
		logic [6:0]      wsum;
		logic [5:0]      d;
		logic [CH_W-1:0] t;
		color_t          out;

		ea  = cap_weight(cfg.alpha_weight_first);
		eb  = cap_weight(cfg.alpha_weight_second);
		ey  = cap_weight(cfg.fade_weight);
		out = '0;
		for (int k = 0; k < NUM_CH; k++) begin
			ca   = sel.a_color[CH_W*k +: CH_W];
			cb   = sel.b_color[CH_W*k +: CH_W];
			inv  = CH_MAX - ca;
			pa   = 10'(ca) * 10'(ea);
			pb   = 10'(cb) * 10'(eb);
			pw   = 10'(inv) * 10'(ey);
			pk   = 10'(ca) * 10'(ey);
			asum = 11'(pa) + 11'(pb);
			wsum = 7'(ca) + 7'(pw[9:4]);
			d    = pk[9:4];
			if (sel.do_alpha) begin
				t = (asum[10:4] > 7'(CH_MAX)) ? CH_MAX : asum[8:4];
			end else if (cfg.blend_mode == MODE_WHITE) begin
				t = (wsum > 7'(CH_MAX)) ? CH_MAX : wsum[4:0];
			end else begin
				t = (d > 6'(ca)) ? '0 : (ca - d[4:0]);
			end
			out[CH_W*k +: CH_W] = t;
		end

		res.modified     = sel.do_alpha | sel.do_fade;
		res.target_layer = res.modified ? sel.layer : '0;
		res.new_color    = res.modified ? out : '0;
	end

endmodule

### sv/layer_blend_select_and_mix.sv
// Colour special effects for one pixel per request.
// Input channel (in_valid / in_stall): four background colours with opaque
// bits, the sprite pixel and the backdrop colour. Output channel
// (out_valid / out_stall): one result per request, giving whether a layer
// pixel was replaced, which layer, and its new colour.
// Configuration: APB write/read, registers at byte address 4*i, pready tied
// high. The user must change registers only while no request is in flight;
// the block itself does not enforce this. An accepted request sits in the
// input register; its result is loaded into the output register, from which
// the receiver takes it. Throughput: one request per cycle while out_stall is
// low, set by the single layer-select and mix stage between the two registers.
// When the receiver stalls, the output register holds its result and the
// input register still takes one more request; in_stall rises only when both
// are full and out_stall is high.
// Reset clears all configuration registers to zero (no effect, nothing
// enabled) and empties both pipeline registers.
module layer_blend_select_and_mix
	import lbsm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [14:0] bg0_color,
	input  logic [14:0] bg1_color,
	input  logic [14:0] bg2_color,
	input  logic [14:0] bg3_color,
	input  logic [3:0]  bg_opaque,
	input  logic [14:0] sprite_color,
	input  logic        sprite_opaque,
	input  logic [1:0]  sprite_priority,
	input  logic        sprite_semi,
	input  logic [14:0] backdrop_color,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        modified,
	output logic [2:0]  target_layer,
	output logic [14:0] new_color
);

	cfg_t cfg;
	pix_t pix_s1;
	sel_t sel;
	res_t res;
	res_t res_s2;
	logic v_s1;
	logic v_s2;
	logic s1_ready;
	logic s2_ready;

	lbsm_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	lbsm_layer_select u_sel (
		.cfg (cfg),
		.pix (pix_s1),
		.sel (sel)
	);

	lbsm_color_mix u_mix (
		.cfg (cfg),
		.sel (sel),
		.res (res)
	);

	assign s2_ready = ~v_s2 | ~out_stall;
	assign s1_ready = ~v_s1 | s2_ready;
	assign in_stall = ~s1_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (s1_ready) v_s1 <= in_valid;
			if (s2_ready) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && s1_ready) begin
			pix_s1.bg_color[0]     <= bg0_color;
			pix_s1.bg_color[1]     <= bg1_color;
			pix_s1.bg_color[2]     <= bg2_color;
			pix_s1.bg_color[3]     <= bg3_color;
			pix_s1.bg_opaque       <= bg_opaque;
			pix_s1.sprite_color    <= sprite_color;
			pix_s1.sprite_opaque   <= sprite_opaque;
			pix_s1.sprite_priority <= sprite_priority;
			pix_s1.sprite_semi     <= sprite_semi;
			pix_s1.backdrop_color  <= backdrop_color;
		end
		if (v_s1 && s2_ready) res_s2 <= res;
	end

	assign out_valid    = v_s2;
	assign modified     = res_s2.modified;
	assign target_layer = res_s2.target_layer;
	assign new_color    = res_s2.new_color;

	a_zero_when_unmodified: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !modified |-> target_layer == '0 && new_color == '0)
		else $error("unmodified result carries non-zero fields");

	a_layer_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && modified |-> target_layer <= LAYER_SPRITE)
		else $error("target layer out of range");

	a_no_effect_mode: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && cfg.blend_mode == MODE_NONE && !pix_s1.sprite_semi |-> !res.modified)
		else $error("effect applied with mode none and no semi-transparent sprite");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !s2_ready |=> v_s1 && $stable(pix_s1))
		else $error("input register lost a blocked request");

	a_fx_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> $onehot0({sel.do_alpha, sel.do_fade}))
		else $error("alpha and fade selected together");

endmodule

### tb/layer_blend_select_and_mix_test.sv
module layer_blend_select_and_mix_test;
	import lbsm_pkg::*;

	localparam int IDLE_PCT       = 14;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int NUM_PHASES     = 12;
	localparam int PHASE_ITEMS    = 84;

	class blend_scoreboard;
		cfg_t cfg;
		res_t pending[$];
		int   errors;

		function new();
			cfg = '0;
			errors = 0;
		endfunction

		function void write_reg(reg_idx_t idx, logic [31:0] v);
			case (idx)
				REG_LAYER_ENABLE:  cfg.layer_enable = v[4:0];
				REG_BG_PRIORITIES: cfg.bg_priorities = v[7:0];
				REG_BLEND_MODE:    cfg.blend_mode = mode_t'(v[1:0]);
				REG_FIRST_TARGET:  cfg.first_target_mask = v[5:0];
				REG_SECOND_TARGET: cfg.second_target_mask = v[5:0];
				REG_ALPHA_FIRST:   cfg.alpha_weight_first = v[4:0];
				REG_ALPHA_SECOND:  cfg.alpha_weight_second = v[4:0];
				REG_FADE_WEIGHT:   cfg.fade_weight = v[4:0];
				default: ;
			endcase
		endfunction

		function int capped(logic [4:0] w);
			return (w > 5'd17) ? 17 : int'(w);
		endfunction

		// priority walk for alpha: layer A then layer B, backdrop as B last
		function bit find_pair(pix_t p, bit vis, output layer_t al, output color_t ac,
				output color_t bc);
			bit     a_set;
			bit     hit;
			int     ly;
			color_t c;
			a_set = 1'b0;
			al = '0;
			ac = '0;
			bc = '0;
			if (vis && p.sprite_semi) begin
				a_set = 1'b1;
				al = LAYER_SPRITE;
				ac = p.sprite_color;
			end
			for (int pr = 0; pr < NUM_PRIO; pr++) begin
				for (int slot = 0; slot <= NUM_BG; slot++) begin
					hit = 1'b0;
					ly = 0;
					c = '0;
					if (slot == 0) begin
						if (vis && !p.sprite_semi && p.sprite_priority == pr) begin
							hit = 1'b1;
							ly = int'(LAYER_SPRITE);
							c = p.sprite_color;
						end
					end else begin
						ly = slot - 1;
						if (cfg.layer_enable[ly] && p.bg_opaque[ly] &&
								cfg.bg_priorities[2*ly +: 2] == pr) begin
							hit = 1'b1;
							c = p.bg_color[ly];
						end
					end
					if (hit) begin
						if (cfg.first_target_mask[ly] && !a_set) begin
							a_set = 1'b1;
							al = layer_t'(ly);
							ac = c;
						end else if (cfg.second_target_mask[ly]) begin
							bc = c;
							return a_set;
						end else begin
							return 1'b0;
						end
					end
				end
			end
			if (a_set && cfg.second_target_mask[BACKDROP_BIT]) begin
				bc = p.backdrop_color;
				return 1'b1;
			end
			return 1'b0;
		endfunction

		// top layer for fades; backdrop lands in the first enabled background
		function bit find_single(pix_t p, bit vis, output layer_t al, output color_t ac);
			al = '0;
			ac = '0;
			if (vis && p.sprite_semi) begin
				al = LAYER_SPRITE;
				ac = p.sprite_color;
				return 1'b1;
			end
			for (int pr = 0; pr < NUM_PRIO; pr++) begin
				if (vis && p.sprite_priority == pr) begin
					if (!cfg.first_target_mask[LAYER_SPRITE])
						return 1'b0;
					al = LAYER_SPRITE;
					ac = p.sprite_color;
					return 1'b1;
				end
				for (int b = 0; b < NUM_BG; b++) begin
					if (cfg.layer_enable[b] && p.bg_opaque[b] &&
							cfg.bg_priorities[2*b +: 2] == pr) begin
						if (!cfg.first_target_mask[b])
							return 1'b0;
						al = layer_t'(b);
						ac = p.bg_color[b];
						return 1'b1;
					end
				end
			end
			if (cfg.first_target_mask[BACKDROP_BIT]) begin
				for (int b = 0; b < NUM_BG; b++) begin
					if (cfg.layer_enable[b]) begin
						al = layer_t'(b);
						ac = p.backdrop_color;
						return 1'b1;
					end
				end
			end
			return 1'b0;
		endfunction

		function color_t mix_alpha(color_t a, color_t b);
			int     ea;
			int     eb;
			int     t;
			color_t o;
			ea = capped(cfg.alpha_weight_first);
			eb = capped(cfg.alpha_weight_second);
			o = '0;
			for (int k = 0; k < NUM_CH; k++) begin
				t = (int'(a[CH_W*k +: CH_W]) * ea + int'(b[CH_W*k +: CH_W]) * eb) >> 4;
				if (t > 31)
					t = 31;
				o[CH_W*k +: CH_W] = t[CH_W-1:0];
			end
			return o;
		endfunction

		function color_t mix_fade(color_t a, bit to_white);
			int     ey;
			int     c;
			int     d;
			int     t;
			color_t o;
			ey = capped(cfg.fade_weight);
			o = '0;
			for (int k = 0; k < NUM_CH; k++) begin
				c = int'(a[CH_W*k +: CH_W]);
				if (to_white) begin
					t = c + (((31 - c) * ey) >> 4);
					if (t > 31)
						t = 31;
				end else begin
					d = (c * ey) >> 4;
					t = (d > c) ? 0 : c - d;
				end
				o[CH_W*k +: CH_W] = t[CH_W-1:0];
			end
			return o;
		endfunction

		function res_t blend_pixel(pix_t p);
			bit     vis;
			bit     done;
			layer_t al;
			color_t ac;
			color_t bc;
			color_t mixed;
			res_t   r;
			vis = cfg.layer_enable[LAYER_SPRITE] && p.sprite_opaque;
			done = 1'b0;
			mixed = '0;
			if (p.sprite_semi && find_pair(p, vis, al, ac, bc)) begin
				mixed = mix_alpha(ac, bc);
				done = 1'b1;
			end
			if (!done) begin
				case (cfg.blend_mode)
					MODE_ALPHA: begin
						if (find_pair(p, vis, al, ac, bc)) begin
							mixed = mix_alpha(ac, bc);
							done = 1'b1;
						end
					end
					MODE_WHITE, MODE_BLACK: begin
						if (find_single(p, vis, al, ac)) begin
							mixed = mix_fade(ac, cfg.blend_mode == MODE_WHITE);
							done = 1'b1;
						end
					end
					default: ;
				endcase
			end
			r = '0;
			if (done) begin
				r.modified = 1'b1;
				r.target_layer = al;
				r.new_color = mixed;
			end
			return r;
		endfunction

		function void note_request(pix_t p);
			pending.push_back(blend_pixel(p));
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (pending.size() == 0) begin
				$error("result with no request outstanding: modified %0d layer %0d colour %h",
					got.modified, got.target_layer, got.new_color);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.modified !== want.modified) begin
				$error("modified: expected %0d, got %0d", want.modified, got.modified);
				errors++;
			end
			if (got.target_layer !== want.target_layer) begin
				$error("target_layer: expected %0d, got %0d", want.target_layer,
					got.target_layer);
				errors++;
			end
			if (got.new_color !== want.new_color) begin
				$error("new_color: expected %h, got %h", want.new_color, got.new_color);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [14:0] bg0_color = '0;
	logic [14:0] bg1_color = '0;
	logic [14:0] bg2_color = '0;
	logic [14:0] bg3_color = '0;
	logic [3:0]  bg_opaque = '0;
	logic [14:0] sprite_color = '0;
	logic        sprite_opaque = 1'b0;
	logic [1:0]  sprite_priority = '0;
	logic        sprite_semi = 1'b0;
	logic [14:0] backdrop_color = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        modified;
	logic [2:0]  target_layer;
	logic [14:0] new_color;

	logic            quiet = 1'b0;
	int              idle_cycles = 0;
	blend_scoreboard board;

	layer_blend_select_and_mix DUT (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall),
		.bg0_color(bg0_color), .bg1_color(bg1_color), .bg2_color(bg2_color),
		.bg3_color(bg3_color), .bg_opaque(bg_opaque), .sprite_color(sprite_color),
		.sprite_opaque(sprite_opaque), .sprite_priority(sprite_priority),
		.sprite_semi(sprite_semi), .backdrop_color(backdrop_color),
		.out_valid(out_valid), .out_stall(out_stall),
		.modified(modified), .target_layer(target_layer), .new_color(new_color)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_result(res_t'({modified, target_layer, new_color}));
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task reg_write(input reg_idx_t idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		board.write_reg(idx, value);
	endtask

	task drain();
		in_valid <= 1'b0;
		while (board.pending.size() != 0)
			@(posedge clk);
	endtask

	task configure(input cfg_t c);
		drain();
		reg_write(REG_LAYER_ENABLE, 32'(c.layer_enable));
		reg_write(REG_BG_PRIORITIES, 32'(c.bg_priorities));
		reg_write(REG_BLEND_MODE, 32'(c.blend_mode));
		reg_write(REG_FIRST_TARGET, 32'(c.first_target_mask));
		reg_write(REG_SECOND_TARGET, 32'(c.second_target_mask));
		reg_write(REG_ALPHA_FIRST, 32'(c.alpha_weight_first));
		reg_write(REG_ALPHA_SECOND, 32'(c.alpha_weight_second));
		reg_write(REG_FADE_WEIGHT, 32'(c.fade_weight));
	endtask

	// valid is left high; the caller lowers it when idling
	task send_pixel(input pix_t px);
		in_valid <= 1'b1;
		bg0_color <= px.bg_color[0];
		bg1_color <= px.bg_color[1];
		bg2_color <= px.bg_color[2];
		bg3_color <= px.bg_color[3];
		bg_opaque <= px.bg_opaque;
		sprite_color <= px.sprite_color;
		sprite_opaque <= px.sprite_opaque;
		sprite_priority <= px.sprite_priority;
		sprite_semi <= px.sprite_semi;
		backdrop_color <= px.backdrop_color;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		board.note_request(px);
	endtask

	function automatic pix_t pixel(color_t c0, color_t c1, color_t c2, color_t c3,
			logic [3:0] op, color_t sc, logic so, logic [1:0] sp, logic ss, color_t bd);
		pix_t px;
		px.bg_color[0] = c0;
		px.bg_color[1] = c1;
		px.bg_color[2] = c2;
		px.bg_color[3] = c3;
		px.bg_opaque = op;
		px.sprite_color = sc;
		px.sprite_opaque = so;
		px.sprite_priority = sp;
		px.sprite_semi = ss;
		px.backdrop_color = bd;
		return px;
	endfunction

	function automatic color_t rand_colour();
		if ($urandom_range(99) < 12) begin
			case ($urandom_range(3))
				0: return 15'h0000;
				1: return 15'h7FFF;
				2: return 15'h001F;
				default: return 15'h7C00;
			endcase
		end
		return color_t'($urandom_range(32767));
	endfunction

	function automatic pix_t rand_pixel();
		return pixel(rand_colour(), rand_colour(), rand_colour(), rand_colour(),
			4'($urandom_range(15)), rand_colour(), 1'($urandom_range(1)),
			2'($urandom_range(3)), $urandom_range(2) == 0, rand_colour());
	endfunction

	function automatic cfg_t rand_cfg(int phase);
		cfg_t c;
		c.layer_enable = ($urandom_range(99) < 60) ? 5'h1F : 5'($urandom_range(31));
		c.bg_priorities = 8'($urandom_range(255));
		c.blend_mode = mode_t'(phase % 4);
		c.first_target_mask = 6'($urandom_range(63));
		c.second_target_mask = 6'($urandom_range(63));
		c.alpha_weight_first = 5'($urandom_range(31));
		c.alpha_weight_second = 5'($urandom_range(31));
		c.fade_weight = 5'($urandom_range(31));
		return c;
	endfunction

	initial begin
		cfg_t c;
		board = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// registers at reset: nothing enabled, no effect
		send_pixel(pixel(15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF, 4'hF, 15'h7FFF, 1, 3, 1,
			15'h7FFF));
		send_pixel(pixel(0, 0, 0, 0, 4'h0, 0, 0, 0, 0, 0));

		// alpha, bg0 as A only, weights above the cap
		c = '{5'h1F, 8'hE4, MODE_ALPHA, 6'h01, 6'h3E, 5'd31, 5'd31, 5'd0};
		configure(c);
		send_pixel(pixel(15'h7FFF, 15'h7FFF, 0, 0, 4'b0011, 0, 0, 0, 0, 0));
		send_pixel(pixel(15'h1234, 0, 0, 0, 4'b0001, 0, 0, 0, 0, 15'h5555));
		send_pixel(pixel(15'h1234, 15'h4321, 0, 0, 4'b0000, 0, 0, 0, 0, 15'h5555));
		send_pixel(pixel(0, 15'h4321, 0, 0, 4'b0010, 0, 0, 0, 0, 15'h5555));
		send_pixel(pixel(15'h1111, 0, 0, 0, 4'b0001, 15'h2A2A, 1, 3, 1, 15'h5555));
		send_pixel(pixel(0, 15'h1111, 0, 0, 4'b0010, 15'h2A2A, 1, 3, 1, 15'h5555));
		send_pixel(pixel(15'h1111, 0, 0, 0, 4'b0001, 15'h2A2A, 1, 0, 0, 15'h5555));

		// fade to white, full strength
		c = '{5'h1F, 8'h00, MODE_WHITE, 6'h3F, 6'h00, 5'd0, 5'd0, 5'd31};
		configure(c);
		send_pixel(pixel(0, 0, 0, 0, 4'hF, 0, 0, 0, 0, 0));
		send_pixel(pixel(0, 0, 0, 0, 4'h0, 0, 0, 0, 0, 15'h0421));
		send_pixel(pixel(0, 0, 0, 0, 4'hF, 15'h03E0, 1, 2, 1, 0));

		// fade to black, backdrop only as A
		c = '{5'h1C, 8'h00, MODE_BLACK, 6'h20, 6'h00, 5'd0, 5'd0, 5'd16};
		configure(c);
		send_pixel(pixel(0, 0, 15'h7FFF, 0, 4'h0, 0, 0, 0, 0, 15'h7FFF));
		send_pixel(pixel(0, 0, 15'h7FFF, 0, 4'b0100, 0, 0, 0, 0, 15'h7FFF));

		// no background enabled: backdrop has nowhere to go
		c = '{5'h10, 8'h00, MODE_BLACK, 6'h20, 6'h00, 5'd0, 5'd0, 5'd8};
		configure(c);
		send_pixel(pixel(0, 0, 0, 0, 4'hF, 15'h7FFF, 0, 0, 0, 15'h7FFF));
		send_pixel(pixel(0, 0, 0, 0, 4'hF, 15'h7FFF, 1, 2, 0, 15'h7FFF));

		// mode none: semi-transparent sprite still blends
		c = '{5'h1F, 8'hFF, MODE_NONE, 6'h10, 6'h0F, 5'd8, 5'd8, 5'd0};
		configure(c);
		send_pixel(pixel(0, 0, 0, 15'h7FFF, 4'b1000, 15'h7FFF, 1, 3, 1, 0));
		send_pixel(pixel(0, 0, 0, 15'h7FFF, 4'b1000, 15'h7FFF, 1, 3, 0, 0));
		send_pixel(pixel(15'h5A5A, 0, 0, 15'h7FFF, 4'b1001, 15'h7FFF, 0, 3, 1, 0));

		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			if (phase == 0)
				c = '{5'h1F, 8'hFF, MODE_BLACK, 6'h3F, 6'h3F, 5'd31, 5'd31, 5'd31};
			else if (phase == 1)
				c = '0;
			else
				c = rand_cfg(phase);
			configure(c);
			quiet <= (phase == 5 || phase == 6);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				while (!quiet && $urandom_range(99) < IDLE_PCT) begin
					in_valid <= 1'b0;
					@(posedge clk);
				end
				send_pixel(rand_pixel());
			end
		end

		drain();
		repeat (4) @(posedge clk);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
